@@ rtl/core/mam_pkg.sv @@
// Package for the moving average and range map block.
// Holds field widths, register indexes, the sequencer state type and the
// control bundle. No dependencies.
package mam_pkg;

  // Field widths of the channels
  localparam int SAMPLE_W   = 10;
  localparam int SPAN_W     = 21;
  localparam int WIN_CFG_W  = 7;
  localparam int CFG_IDX_W  = 2;

  // Full scale of the converter, the default ring depth and the window after reset
  localparam int SAMPLE_MAX     = 1023;
  localparam int RING_DEPTH_DEF = 64;
  localparam int WIN_RESET      = 8;

  // Magnitude of mean times span difference: 10 bits by 21 bits
  localparam int PROD_W = SAMPLE_W + SPAN_W;
  localparam int CNT_W  = $clog2(PROD_W);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_HI = 2'd2;

  typedef logic [SAMPLE_W-1:0]      sample_t;
  typedef logic signed [SPAN_W-1:0] span_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_MEAN,
    ST_MUL,
    ST_MAP,
    ST_DONE
  } state_t;

  // Strobes from the sequencer output decode to the datapath
  typedef struct packed {
    logic take_in;
    logic upd;
    logic div_step;
    logic mean_ld;
    logic mul_step;
    logic load_out;
  } ctrl_t;

endpackage

@@ rtl/core/mam_in_if.sv @@
// Input channel: one converter sample per word.
// Depends on mam_pkg for the sample type.
interface mam_in_if;
  logic             valid;
  logic             ready;
  mam_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ rtl/core/mam_out_if.sv @@
// Result channel: mean and mapped mean per word.
// Depends on mam_pkg for the field types.
interface mam_out_if;
  logic             valid;
  logic             ready;
  mam_pkg::sample_t mean;
  mam_pkg::span_t   scaled;

  modport source (output valid, output mean, output scaled, input ready);
  modport sink   (input valid, input mean, input scaled, output ready);
endinterface

@@ rtl/core/mam_cfg_if.sv @@
// Configuration write channel: register index and write data per word.
// Depends on mam_pkg for the widths.
interface mam_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mam_pkg::CFG_IDX_W-1:0]    index;
  logic [mam_pkg::SPAN_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/mam_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mam_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/moving_average_range_map_top.sv @@
// Boxcar moving average of converter samples with a linear range map.
// Depends on mam_pkg, the three channel interfaces and mam_ram.
//
//   channel  dir  payload                       width
//   in_ch    in   sample                        10
//   out_ch   out  mean, scaled (signed)         10, 21
//   cfg_ch   in   index, data                   2, 21
//
// From accept to result, one shared bit-serial divider runs SUM_W steps for
// the mean and PROD_W steps for the divide by 1023, with a 10-step shift-add
// multiply between. The next sample is taken only once the result of the last
// one has been loaded into the output register; a stalled output holds the
// sequencer in its last state. Synchronous reset clears the ring through
// per-entry valid bits; configuration words are always taken.
module moving_average_range_map_top #(
  parameter int RING_DEPTH = mam_pkg::RING_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  mam_in_if.sink        in_ch,
  mam_out_if.source     out_ch,
  mam_cfg_if.sink       cfg_ch
);

  localparam int WIN_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = mam_pkg::SAMPLE_W + WIN_W;
  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int WIN_RST = (mam_pkg::WIN_RESET > RING_DEPTH) ? RING_DEPTH
                                                             : mam_pkg::WIN_RESET;
  localparam int SW  = mam_pkg::SAMPLE_W;
  localparam int PW  = mam_pkg::PROD_W;
  localparam int NW  = mam_pkg::SPAN_W;

  mam_pkg::state_t state_r, state_nxt;
  mam_pkg::ctrl_t  ctrl;

  logic [WIN_W-1:0]        win_r;
  mam_pkg::span_t          span_lo_r, span_hi_r;
  logic [RING_DEPTH-1:0]   vld_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [SUM_W-1:0]        sum_r;
  mam_pkg::sample_t        smp_r;
  logic                    old_vld_r;
  logic [PW-1:0]           dvd_r;
  logic [SW-1:0]           rem_r;
  logic [mam_pkg::CNT_W-1:0] cnt_r;
  logic [SW-1:0]           mpl_r;
  mam_pkg::sample_t        mean_r;
  logic                    neg_r;
  logic [NW-1:0]           mag_r;
  logic                    out_valid_r;
  mam_pkg::sample_t        out_mean_r;
  mam_pkg::span_t          out_scaled_r;

  logic [SW-1:0]           ram_rdata;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mam_pkg::ST_IDLE: if (in_ch.valid) state_nxt = mam_pkg::ST_UPD;
      mam_pkg::ST_UPD:  state_nxt = mam_pkg::ST_DIV;
      mam_pkg::ST_DIV:  if (cnt_r == '0) state_nxt = mam_pkg::ST_MEAN;
      mam_pkg::ST_MEAN: state_nxt = mam_pkg::ST_MUL;
      mam_pkg::ST_MUL:  if (cnt_r == '0) state_nxt = mam_pkg::ST_MAP;
      mam_pkg::ST_MAP:  if (cnt_r == '0) state_nxt = mam_pkg::ST_DONE;
      mam_pkg::ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = mam_pkg::ST_IDLE;
      default:          state_nxt = mam_pkg::ST_IDLE;
    endcase
  end

  // Sequencer output decode
  always_comb begin
    ctrl          = '0;
    in_ch.ready   = 1'b0;
    unique case (state_r)
      mam_pkg::ST_IDLE: begin
        in_ch.ready  = 1'b1;
        ctrl.take_in = in_ch.valid;
      end
      mam_pkg::ST_UPD:  ctrl.upd      = 1'b1;
      mam_pkg::ST_DIV:  ctrl.div_step = 1'b1;
      mam_pkg::ST_MEAN: ctrl.mean_ld  = 1'b1;
      mam_pkg::ST_MUL:  ctrl.mul_step = 1'b1;
      mam_pkg::ST_MAP:  ctrl.div_step = 1'b1;
      mam_pkg::ST_DONE: ctrl.load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mam_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Ring store
  mam_ram #(
    .WIDTH (SW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ctrl.upd),
    .waddr (slot_r),
    .wdata (smp_r),
    .re    (ctrl.take_in),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  // Sum update and slot advance
  logic [SW-1:0]    old_smp;
  logic [SUM_W-1:0] sum_nxt;
  logic [WIN_W-1:0] slot_inc;
  logic [SLOT_W-1:0] slot_nxt;

  always_comb begin
    old_smp  = old_vld_r ? ram_rdata : '0;
    sum_nxt  = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
    slot_inc = WIN_W'(slot_r) + WIN_W'(1);
    slot_nxt = (slot_inc >= win_r) ? '0 : SLOT_W'(slot_inc);
  end

  // Span difference as sign and magnitude
  logic signed [NW:0] span_diff;
  logic [NW:0]        span_mag;

  always_comb begin
    span_diff = {span_hi_r[NW-1], span_hi_r} - {span_lo_r[NW-1], span_lo_r};
    span_mag  = span_diff[NW] ? -span_diff : span_diff;
  end

  // Shared divider step: one quotient bit a cycle
  logic [SW-1:0] divisor;
  logic [SW+1:0] trial;
  logic          ge;
  logic [SW-1:0] rem_nxt;

  always_comb begin
    divisor = (state_r == mam_pkg::ST_DIV) ? SW'(win_r) : SW'(mam_pkg::SAMPLE_MAX);
    trial   = {1'b0, rem_r, dvd_r[PW-1]} - {2'b00, divisor};
    ge      = !trial[SW+1];
    rem_nxt = ge ? trial[SW-1:0] : {rem_r[SW-2:0], dvd_r[PW-1]};
  end

  // Mean from the quotient, saturated to full scale
  logic [SUM_W-1:0]  quo;
  mam_pkg::sample_t  mean_sat;

  always_comb begin
    quo      = dvd_r[SUM_W-1:0];
    mean_sat = (|quo[SUM_W-1:SW]) ? SW'(mam_pkg::SAMPLE_MAX) : quo[SW-1:0];
  end

  // Multiply step and final map
  logic [PW-1:0]      mul_nxt;
  logic signed [NW:0] map_res;
  logic [NW:0]        q_map;

  always_comb begin
    mul_nxt = {dvd_r[PW-2:0], 1'b0} + (mpl_r[SW-1] ? PW'(mag_r) : '0);
    q_map   = dvd_r[NW:0];
    map_res = neg_r ? {span_lo_r[NW-1], span_lo_r} - q_map
                    : {span_lo_r[NW-1], span_lo_r} + q_map;
  end

  // Window clamp on a write
  logic [mam_pkg::WIN_CFG_W-1:0] cfg_win;
  logic [WIN_W-1:0]              win_wr;

  always_comb begin
    cfg_win = cfg_ch.data[mam_pkg::WIN_CFG_W-1:0];
    if (cfg_win == '0) begin
      win_wr = WIN_W'(1);
    end else if (int'(cfg_win) > RING_DEPTH) begin
      win_wr = WIN_W'(RING_DEPTH);
    end else begin
      win_wr = WIN_W'(cfg_win);
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Window state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WIN_W'(WIN_RST);
      span_lo_r <= '0;
      span_hi_r <= NW'(1000000);
      vld_r     <= '0;
      slot_r    <= '0;
      sum_r     <= '0;
    end else begin
      if (ctrl.upd) begin
        sum_r         <= sum_nxt;
        vld_r[slot_r] <= 1'b1;
        slot_r        <= slot_nxt;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          mam_pkg::REG_WINDOW: begin
            win_r  <= win_wr;
            vld_r  <= '0;
            sum_r  <= '0;
            slot_r <= '0;
          end
          mam_pkg::REG_SPAN_LO: span_lo_r <= cfg_ch.data;
          mam_pkg::REG_SPAN_HI: span_hi_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (ctrl.take_in) begin
      smp_r     <= in_ch.sample;
      old_vld_r <= vld_r[slot_r];
    end
    if (ctrl.upd) begin
      dvd_r <= PW'(sum_nxt) << (PW - SUM_W);
      rem_r <= '0;
      cnt_r <= mam_pkg::CNT_W'(SUM_W - 1);
      neg_r <= span_diff[NW];
      mag_r <= span_mag[NW-1:0];
    end
    if (ctrl.div_step) begin
      dvd_r <= {dvd_r[PW-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - mam_pkg::CNT_W'(1);
    end
    if (ctrl.mean_ld) begin
      mean_r <= mean_sat;
      mpl_r  <= mean_sat;
      dvd_r  <= '0;
      rem_r  <= '0;
      cnt_r  <= mam_pkg::CNT_W'(SW - 1);
    end
    if (ctrl.mul_step) begin
      dvd_r <= mul_nxt;
      mpl_r <= {mpl_r[SW-2:0], 1'b0};
      cnt_r <= (cnt_r == '0) ? mam_pkg::CNT_W'(PW - 1) : cnt_r - mam_pkg::CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_scaled_r <= '0;
    end else if (ctrl.load_out) begin
      out_valid_r  <= 1'b1;
      out_mean_r   <= mean_r;
      out_scaled_r <= map_res[NW-1:0];
    end else if (out_ch.ready) begin
      out_valid_r  <= 1'b0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.mean   = out_mean_r;
  assign out_ch.scaled = out_scaled_r;

  // Checks on the sequencer, window state and output register
  a_upd_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mam_pkg::ST_UPD) |-> $past(ctrl.take_in))
    else $error("update without an accepted sample");

  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (WIN_W'(slot_r) < win_r))
    else $error("write slot outside the window");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(sum_r) <= mam_pkg::SAMPLE_MAX * RING_DEPTH))
    else $error("running sum above full scale");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_out |-> (!out_valid_r || out_ch.ready))
    else $error("pending result overwritten");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mam_pkg::ST_DIV) |-> (int'(cnt_r) < SUM_W))
    else $error("mean divider count out of range");

endmodule

@@ tb/moving_average_range_map_top_tb.sv @@
// Self-checking testbench for moving_average_range_map_top: a directed table, then random
// phases of samples under new window and span settings, checked word by word against an
// in-bench predictor. Depends on mam_pkg, the three channel interfaces and the block itself.
module moving_average_range_map_top_tb;

  localparam int RING_DEPTH      = mam_pkg::RING_DEPTH_DEF;
  localparam int NUM_DIRECTED    = 25;
  localparam int NUM_PHASES      = 23;
  localparam int WORDS_PER_PHASE = 70;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 70;

  // Index 3 has no register behind it
  localparam logic [mam_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One directed step: a sample (in data) or a register write, with an optional fixed result
  typedef struct packed {
    row_kind_t                     kind;
    logic [mam_pkg::CFG_IDX_W-1:0] idx;
    logic [mam_pkg::SPAN_W-1:0]    data;
    logic                          pin;
    mam_pkg::sample_t              mean;
    mam_pkg::span_t                scaled;
  } dir_row_t;

  typedef struct {
    mam_pkg::sample_t mean;
    mam_pkg::span_t   scaled;
  } avg_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mam_in_if  in_ch();
  mam_out_if out_ch();
  mam_cfg_if cfg_ch();

  moving_average_range_map_top #(.RING_DEPTH(RING_DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: window contents, running sum and the map settings
  mam_pkg::sample_t win_samples [RING_DEPTH];
  int unsigned      win_sum;
  int unsigned      win_slot;
  int unsigned      win_len;
  mam_pkg::span_t   map_lo;
  mam_pkg::span_t   map_hi;

  avg_word_t   expected_avgs [$];
  int unsigned mismatches = 0;

  // Fixed result for the word currently offered, set by the sender
  logic             pin_on = 1'b0;
  mam_pkg::sample_t pin_mean = '0;
  mam_pkg::span_t   pin_scaled = '0;

  // Idling controls shared between the stimulus and the receiver
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // after reset: window of eight, span 0..1000000
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b1, 10'd127,  21'sd124144},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd0,       1'b1, 10'd127,  21'sd124144},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b0, 10'd0,    21'sd0},
    // window written as zero acts as one; upper data bits are ignored
    '{ROW_WRITE,  mam_pkg::REG_WINDOW,  21'h1FFF80,  1'b0, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b1, 10'd1023, 21'sd1000000},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd0,       1'b1, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd511,     1'b0, 10'd0,    21'sd0},
    // window above the ring saturates
    '{ROW_WRITE,  mam_pkg::REG_WINDOW,  21'd127,     1'b0, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b0, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b0, 10'd0,    21'sd0},
    // full 21-bit span, rising
    '{ROW_WRITE,  mam_pkg::REG_SPAN_LO, 21'h100000,  1'b0, 10'd0,    21'sd0},
    '{ROW_WRITE,  mam_pkg::REG_SPAN_HI, 21'h0FFFFF,  1'b0, 10'd0,    21'sd0},
    '{ROW_WRITE,  mam_pkg::REG_WINDOW,  21'd1,       1'b0, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd0,       1'b1, 10'd0,    -21'sd1048576},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b1, 10'd1023, 21'sd1048575},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd512,     1'b0, 10'd0,    21'sd0},
    // reversed span gives a falling map
    '{ROW_WRITE,  mam_pkg::REG_SPAN_LO, 21'h0FFFFF,  1'b0, 10'd0,    21'sd0},
    '{ROW_WRITE,  mam_pkg::REG_SPAN_HI, 21'h100000,  1'b0, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd0,       1'b1, 10'd0,    21'sd1048575},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b1, 10'd1023, -21'sd1048576},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd300,     1'b0, 10'd0,    21'sd0},
    // write to an unused index leaves everything as is
    '{ROW_WRITE,  REG_UNUSED,           21'h0AAAAA,  1'b0, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd1023,    1'b1, 10'd1023, -21'sd1048576},
    '{ROW_WRITE,  mam_pkg::REG_WINDOW,  21'd64,      1'b0, 10'd0,    21'sd0},
    '{ROW_SAMPLE, mam_pkg::REG_WINDOW,  21'd682,     1'b0, 10'd0,    21'sd0}
  };

  // Clock
  always #5 clk = ~clk;

  // Run limit, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Empty the window and restart at slot zero
  function automatic void clear_window();
    foreach (win_samples[i]) win_samples[i] = '0;
    win_sum  = 0;
    win_slot = 0;
  endfunction

  // Apply one configuration word to the predictor
  function automatic void apply_register(logic [mam_pkg::CFG_IDX_W-1:0] idx,
                                         logic [mam_pkg::SPAN_W-1:0] data);
    int unsigned w;
    case (idx)
      mam_pkg::REG_WINDOW: begin
        w = 32'(data[mam_pkg::WIN_CFG_W-1:0]);
        if (w == 0) w = 1;
        if (w > RING_DEPTH) w = RING_DEPTH;
        win_len = w;
        clear_window();
      end
      mam_pkg::REG_SPAN_LO: map_lo = mam_pkg::span_t'(data);
      mam_pkg::REG_SPAN_HI: map_hi = mam_pkg::span_t'(data);
      default: ;
    endcase
  endfunction

  // Insert a sample, then compute the truncated mean and its mapped value
  function automatic avg_word_t predict_average(mam_pkg::sample_t s);
    avg_word_t   r;
    int unsigned slot;
    int unsigned m;
    longint      m_wide;
    longint      diff;
    longint      mapped;
    slot = win_slot;
    if (slot >= win_len) slot = 0;
    win_sum = win_sum - 32'(win_samples[slot]) + 32'(s);
    win_samples[slot] = s;
    slot++;
    if (slot >= win_len) slot = 0;
    win_slot = slot;
    m = win_sum / win_len;
    if (m > mam_pkg::SAMPLE_MAX) m = mam_pkg::SAMPLE_MAX;
    m_wide = longint'(m);
    diff   = longint'(map_hi) - longint'(map_lo);
    mapped = (m_wide * diff) / mam_pkg::SAMPLE_MAX + longint'(map_lo);
    r.mean   = mam_pkg::sample_t'(m);
    r.scaled = mam_pkg::span_t'(mapped);
    return r;
  endfunction

  // Track accepted words on all three channels at the rising edge
  always @(posedge clk) begin
    avg_word_t predicted;
    avg_word_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_register(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        predicted = predict_average(in_ch.sample);
        if (pin_on) begin
          predicted.mean   = pin_mean;
          predicted.scaled = pin_scaled;
        end
        expected_avgs.push_back(predicted);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_avgs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word: mean %0d scaled %0d",
                   $time, out_ch.mean, out_ch.scaled);
        end else begin
          want = expected_avgs.pop_front();
          if (out_ch.mean !== want.mean) begin
            mismatches++;
            $display("%0t: mean mismatch: expected %0d, actual %0d",
                     $time, want.mean, out_ch.mean);
          end
          if (out_ch.scaled !== want.scaled) begin
            mismatches++;
            $display("%0t: scaled mismatch: expected %0d, actual %0d",
                     $time, want.scaled, out_ch.scaled);
          end
        end
      end
    end
  end

  // Receiver: random stall before each result word, one long hold-off on request
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one sample word after a random gap and hold it until taken
  task automatic send_word(mam_pkg::sample_t s, logic pin, mam_pkg::sample_t m,
                           mam_pkg::span_t sc);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) repeat (gap) @(negedge clk);
    pin_on       = pin;
    pin_mean     = m;
    pin_scaled   = sc;
    in_ch.sample = s;
    in_ch.valid  = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
    pin_on      = 1'b0;
  endtask

  // Write one configuration register
  task automatic write_reg(logic [mam_pkg::CFG_IDX_W-1:0] idx,
                           logic [mam_pkg::SPAN_W-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Wait until every expected result word has come back
  task automatic drain_results();
    while (expected_avgs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random span value: extremes, zero, the nominal range, or any 21-bit value
  function automatic logic [mam_pkg::SPAN_W-1:0] rand_span();
    int v;
    case ($urandom_range(0, 5))
      0: v = -1048576;
      1: v = 1048575;
      2: v = 0;
      3: v = $urandom;
      default: v = int'($urandom_range(0, 2000000)) - 1000000;
    endcase
    return v[mam_pkg::SPAN_W-1:0];
  endfunction

  // Random window write data, upper bits random too
  function automatic logic [mam_pkg::SPAN_W-1:0] rand_window(int unsigned phase);
    logic [mam_pkg::SPAN_W-1:0] d;
    int unsigned                w;
    case (phase)
      0: w = 1;
      1: w = RING_DEPTH;
      2: w = 0;
      3: w = 127;
      default: begin
        case ($urandom_range(0, 7))
          0: w = 0;
          1: w = 1;
          2: w = RING_DEPTH;
          3: w = $urandom_range(RING_DEPTH + 1, 127);
          4, 5: w = $urandom_range(1, 16);
          default: w = $urandom_range(1, RING_DEPTH);
        endcase
      end
    endcase
    d = mam_pkg::SPAN_W'($urandom);
    d[mam_pkg::WIN_CFG_W-1:0] = w[mam_pkg::WIN_CFG_W-1:0];
    return d;
  endfunction

  // Stimulus
  initial begin
    dir_row_t         row;
    mam_pkg::sample_t s;
    mam_pkg::sample_t prev;
    int               step;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    map_lo  = '0;
    map_hi  = 21'sd1000000;
    win_len = mam_pkg::WIN_RESET;
    clear_window();
    prev = '0;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.idx, row.data);
      end else begin
        send_word(row.data[mam_pkg::SAMPLE_W-1:0], row.pin, row.mean, row.scaled);
      end
    end

    // Random phases, most of them under a new setting
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      steady = (ph % 4 == 3);
      if (ph < 4 || $urandom_range(0, 9) < 7) write_reg(mam_pkg::REG_WINDOW, rand_window(ph));
      if ($urandom_range(0, 9) < 8) write_reg(mam_pkg::REG_SPAN_LO, rand_span());
      if ($urandom_range(0, 9) < 8) write_reg(mam_pkg::REG_SPAN_HI, rand_span());
      if ($urandom_range(0, 9) < 2) write_reg(REG_UNUSED, mam_pkg::SPAN_W'($urandom));
      if (ph == 5) hold_request = 1'b1;
      for (int unsigned k = 0; k < WORDS_PER_PHASE; k++) begin
        case ($urandom_range(0, 9))
          6, 7: s = $urandom_range(0, 1) ? mam_pkg::sample_t'(mam_pkg::SAMPLE_MAX) : '0;
          8, 9: begin
            // slow drift around the previous reading
            step = int'(prev) + int'($urandom_range(0, 16)) - 8;
            if (step < 0) step = 0;
            if (step > mam_pkg::SAMPLE_MAX) step = mam_pkg::SAMPLE_MAX;
            s = mam_pkg::sample_t'(step);
          end
          default: s = mam_pkg::sample_t'($urandom);
        endcase
        prev = s;
        send_word(s, 1'b0, '0, '0);
      end
    end

    // Let the last results arrive, then give the block time to misbehave
    steady = 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_avgs.size() != 0) begin
      mismatches++;
      $display("%0t: %0d result words never arrived", $time, expected_avgs.size());
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
